FILE: hw/rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the bilinear bayer demosaic block.
// ----------------------------------------------------------------------------
package bbd_pkg;

  // default line store depth, pixels per row at most
  localparam int unsigned MAX_WIDTH_DEF = 4096;

  // field widths
  localparam int unsigned XW     = 13;  // column counter, holds up to 8191
  localparam int unsigned YW     = 16;  // row counter and out_y
  localparam int unsigned OXW    = 12;  // out_x
  localparam int unsigned CFG_DW = 16;  // config write data

  // register reset values
  localparam logic [XW-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [YW-1:0] FRAME_HEIGHT_RST = 16'd480;

  // smallest frame extent in either direction
  localparam logic [XW-1:0] MIN_W = 13'd3;
  localparam logic [YW-1:0] MIN_H = 16'd3;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

  // one window column, top row first
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

endpackage

FILE: hw/rtl/bbd_if.sv
// ----------------------------------------------------------------------------
// bbd_if
// Valid/ready channels of the demosaic block: pixels in, results out, config.
// ----------------------------------------------------------------------------
interface bbd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_r;
  logic [7:0] chan_g;
  logic [7:0] chan_b;
  logic       frame_start;

  modport source (output valid, chan_r, chan_g, chan_b, frame_start, input ready);
  modport sink   (input valid, chan_r, chan_g, chan_b, frame_start, output ready);
endinterface

interface bbd_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_x;
  logic [15:0] out_y;
  logic [7:0]  out_r;
  logic [7:0]  out_g;
  logic [7:0]  out_b;
  logic        last_of_run;

  modport source (output valid, out_x, out_y, out_r, out_g, out_b, last_of_run,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_r, out_g, out_b, last_of_run,
                  output ready);
endinterface

interface bbd_cfg_if;
  import bbd_pkg::*;
  logic                valid;
  logic                ready;
  cfg_reg_t            index;
  logic [CFG_DW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/bilinear_bayer_demosaic.sv
// ----------------------------------------------------------------------------
// bilinear_bayer_demosaic
// Streaming bilinear demosaic of an RGGB mosaic with two line stores and a
// 3x3 window built from a chain of column cells.
// ----------------------------------------------------------------------------
//
//  channel   dir  transaction
//  -------   ---  ----------------------------------------------------------
//  cfg       in   register index and write data (frame_width, frame_height)
//  pixels    in   one raster pixel: chan_r, chan_g, chan_b, frame_start
//  results   out  one demosaiced pixel with out_x, out_y and last_of_run
//
//  An input pixel that yields one result is taken every cycle while results are
//  taken; a pixel that yields two or three results (end of row, last row) holds
//  the input while the output register drains them one per cycle as taken.
//  The first result of a pixel is registered in the read stage and then in the
//  result register; the rate is set by the single result register feeding the
//  output channel.
//  Reset is synchronous and clears counters, window and pipeline valids; the
//  line stores need no clearing pass and hold garbage until first written.
//  Output stalls back up through the result register into the read stage and
//  then drop pixels.ready; cfg is always ready.
//
module bilinear_bayer_demosaic #(
  parameter int unsigned MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bbd_cfg_if.sink    cfg,
  bbd_pix_if.sink    pixels,
  bbd_res_if.source  results
);
  import bbd_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef struct packed {
    logic [OXW-1:0] x;
    logic [YW-1:0]  y;
    pix_t           pix;
  } res_t;

  // config registers
  logic [XW-1:0] frame_width;
  logic [YW-1:0] frame_height;
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;

  // position counters
  logic [XW-1:0] col_cnt;
  logic [YW-1:0] row_cnt;

  // accept side
  logic          in_acc;
  logic [XW-1:0] x_in;
  logic [YW-1:0] y_in;
  logic          lastcol_in;
  logic          lastrow_in;
  logic          interior_in;
  logic [AW-1:0] idx_in;
  logic [2:0]    mask_in;

  // read stage
  logic          s1_valid;
  logic          s1_fire;
  pix_t          s1_cur;
  logic [XW-1:0] s1_x;
  logic [YW-1:0] s1_y;
  logic [AW-1:0] s1_idx;
  logic          s1_interior;
  logic [2:0]    s1_mask;
  logic          s1_fwd;
  pix_t          s1_fwd_top;
  pix_t          s1_fwd_mid;
  pix_t          top_rd;
  pix_t          mid_rd;
  pix_t          s1_top;
  pix_t          s1_mid;

  // window
  col_t          new_col;
  col_t          cell0_q;
  col_t          cell1_q;
  pix_t          interp_pix;
  pix_t          pix_a;

  // result register, one slot per possible result of a pixel
  logic [2:0]    em_mask;
  logic [2:0]    em_mask_next;
  logic          em_free;
  res_t          em_slot0;
  res_t          em_slot1;
  res_t          em_slot2;
  res_t          em_sel;
  logic          em_last;

  // --------------------------------------------------------------------------
  // config
  // --------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data[XW-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // clamp to the supported frame range
  always_comb begin
    w_eff = (frame_width < MIN_W) ? MIN_W : frame_width;
    if (32'(w_eff) > MAX_WIDTH) begin
      w_eff = XW'(MAX_WIDTH);
    end
    h_eff = (frame_height < MIN_H) ? MIN_H : frame_height;
  end

  // --------------------------------------------------------------------------
  // input transaction, position and flags
  // --------------------------------------------------------------------------
  assign in_acc       = pixels.valid && pixels.ready;
  assign pixels.ready = !s1_valid || s1_fire;

  assign x_in        = pixels.frame_start ? '0 : col_cnt;
  assign y_in        = pixels.frame_start ? '0 : row_cnt;
  assign lastcol_in  = x_in >= (w_eff - XW'(1));
  assign lastrow_in  = y_in >= (h_eff - YW'(1));
  // centre one pixel up and left lies inside the frame border
  assign interior_in = (x_in >= XW'(2)) && (x_in <= (w_eff - XW'(1)))
                    && (y_in >= YW'(2)) && (y_in <= (h_eff - YW'(1)));
  assign idx_in      = (32'(x_in) < MAX_WIDTH) ? AW'(x_in) : AW'(MAX_WIDTH - 1);

  // bit 0: window centre, bit 1: end of row above, bit 2: last row pass-through
  assign mask_in[0] = (x_in != '0) && (y_in != '0);
  assign mask_in[1] = (y_in != '0) && lastcol_in;
  assign mask_in[2] = lastrow_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_acc) begin
      if (lastcol_in) begin
        col_cnt <= '0;
        row_cnt <= lastrow_in ? '0 : (y_in + YW'(1));
      end else begin
        col_cnt <= x_in + XW'(1);
        row_cnt <= y_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // line stores, read on accept, written when the pixel leaves the read stage
  // --------------------------------------------------------------------------
  bbd_line_buf #(.DEPTH(MAX_WIDTH), .AW(AW)) u_older (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_idx),
    .wdata (s1_mid),
    .re    (in_acc),
    .raddr (idx_in),
    .rdata (top_rd)
  );

  bbd_line_buf #(.DEPTH(MAX_WIDTH), .AW(AW)) u_newer (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_idx),
    .wdata (s1_cur),
    .re    (in_acc),
    .raddr (idx_in),
    .rdata (mid_rd)
  );

  // --------------------------------------------------------------------------
  // read stage
  // --------------------------------------------------------------------------
  assign em_mask_next = em_mask & (em_mask - 3'd1);
  assign em_free      = (em_mask == 3'b000) || (results.ready && (em_mask_next == 3'b000));
  assign s1_fire      = s1_valid && em_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur      <= '{b: pixels.chan_b, g: pixels.chan_g, r: pixels.chan_r};
      s1_x        <= x_in;
      s1_y        <= y_in;
      s1_idx      <= idx_in;
      s1_interior <= interior_in;
      s1_mask     <= mask_in;
      // same entry written this edge: the registered read is stale
      s1_fwd      <= s1_fire && (s1_idx == idx_in);
      s1_fwd_top  <= s1_mid;
      s1_fwd_mid  <= s1_cur;
    end
  end

  assign s1_top = s1_fwd ? s1_fwd_top : top_rd;
  assign s1_mid = s1_fwd ? s1_fwd_mid : mid_rd;

  // --------------------------------------------------------------------------
  // window: incoming column plus two cells shifting left on each pixel
  // --------------------------------------------------------------------------
  assign new_col = '{top: s1_top, mid: s1_mid, bot: s1_cur};

  bbd_cell u_cell1 (
    .clk (clk),
    .rst (rst),
    .en  (s1_fire),
    .d   (new_col),
    .q   (cell1_q)
  );

  bbd_cell u_cell0 (
    .clk (clk),
    .rst (rst),
    .en  (s1_fire),
    .d   (cell1_q),
    .q   (cell0_q)
  );

  // centre sits one column left of and one row above the incoming pixel, so both parities flip
  bbd_interp u_interp (
    .left   (cell0_q),
    .center (cell1_q),
    .right  (new_col),
    .odd_x  (~s1_x[0]),
    .odd_y  (~s1_y[0]),
    .pix    (interp_pix)
  );

  // border pixels pass through unchanged
  assign pix_a = s1_interior ? interp_pix : cell1_q.mid;

  // --------------------------------------------------------------------------
  // result register, drains its slots in order one per cycle while results.ready is high
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      em_mask <= 3'b000;
    end else if (s1_fire) begin
      em_mask <= s1_mask;
    end else if (results.valid && results.ready) begin
      em_mask <= em_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      em_slot0 <= '{x: OXW'(s1_x - XW'(1)), y: s1_y - YW'(1), pix: pix_a};
      em_slot1 <= '{x: OXW'(s1_x),          y: s1_y - YW'(1), pix: s1_mid};
      em_slot2 <= '{x: OXW'(s1_x),          y: s1_y,          pix: s1_cur};
    end
  end

  always_comb begin
    priority if (em_mask[0]) begin
      em_sel  = em_slot0;
      em_last = (em_mask[2:1] == 2'b00);
    end else if (em_mask[1]) begin
      em_sel  = em_slot1;
      em_last = !em_mask[2];
    end else begin
      em_sel  = em_slot2;
      em_last = 1'b1;
    end
  end

  assign results.valid       = |em_mask;
  assign results.out_x       = em_sel.x;
  assign results.out_y       = em_sel.y;
  assign results.out_r       = em_sel.pix.r;
  assign results.out_g       = em_sel.pix.g;
  assign results.out_b       = em_sel.pix.b;
  assign results.last_of_run = em_last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // a run of results continues without a gap until its last one
  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && !results.last_of_run |=> results.valid)
    else $error("result run broken before last_of_run");

  // back-to-back pixels at the same column take the bypassed row data
  a_fwd_taken: assert property (@(posedge clk) disable iff (rst)
    in_acc && s1_fire && (s1_idx == idx_in) |=> s1_fwd)
    else $error("line store bypass missed");

  // a last-row pixel always produces its pass-through result
  a_lastrow_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_mask[2] |=> results.valid && em_mask[2])
    else $error("last row result lost");

endmodule

FILE: hw/rtl/bbd_line_buf.sv
// ----------------------------------------------------------------------------
// bbd_line_buf
// One row of pixels, single write port and registered read port.
// ----------------------------------------------------------------------------
module bbd_line_buf #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  bbd_pkg::pix_t wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output bbd_pkg::pix_t rdata
);
  import bbd_pkg::*;

  pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read sees the old entry when the same address is written this edge
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/bbd_cell.sv
// ----------------------------------------------------------------------------
// bbd_cell
// One column of the 3x3 window; takes its neighbor's column on each shift.
// ----------------------------------------------------------------------------
module bbd_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  bbd_pkg::col_t d,
  output bbd_pkg::col_t q
);
  import bbd_pkg::*;

  col_t col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (en) begin
      col <= d;
    end
  end

  assign q = col;

endmodule

FILE: hw/rtl/bbd_interp.sv
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear fill of the two missing channels at the window center.
// ----------------------------------------------------------------------------
module bbd_interp (
  input  bbd_pkg::col_t left,
  input  bbd_pkg::col_t center,
  input  bbd_pkg::col_t right,
  input  logic          odd_x,
  input  logic          odd_y,
  output bbd_pkg::pix_t pix
);
  import bbd_pkg::*;

  logic [7:0] cross_g;
  logic [7:0] diag_r;
  logic [7:0] diag_b;
  logic [7:0] vert_r;
  logic [7:0] vert_b;
  logic [7:0] horz_r;
  logic [7:0] horz_b;

  // every term truncated before the add, as the sums never overflow 8 bits
  assign cross_g = (center.top.g >> 2) + (center.bot.g >> 2)
                 + (left.mid.g >> 2)   + (right.mid.g >> 2);
  assign diag_r  = (left.top.r >> 2) + (right.top.r >> 2)
                 + (left.bot.r >> 2) + (right.bot.r >> 2);
  assign diag_b  = (left.top.b >> 2) + (right.top.b >> 2)
                 + (left.bot.b >> 2) + (right.bot.b >> 2);
  assign vert_r  = (center.top.r >> 1) + (center.bot.r >> 1);
  assign vert_b  = (center.top.b >> 1) + (center.bot.b >> 1);
  assign horz_r  = (left.mid.r >> 1) + (right.mid.r >> 1);
  assign horz_b  = (left.mid.b >> 1) + (right.mid.b >> 1);

  always_comb begin
    pix = center.mid;
    unique case ({odd_x, odd_y})
      2'b00: begin  // red site
        pix.g = cross_g;
        pix.b = diag_b;
      end
      2'b11: begin  // blue site
        pix.r = diag_r;
        pix.g = cross_g;
      end
      2'b01: begin  // green on a blue row
        pix.r = vert_r;
        pix.b = horz_b;
      end
      default: begin  // green on a red row
        pix.r = horz_r;
        pix.b = vert_b;
      end
    endcase
  end

endmodule

FILE: verif/tb_bilinear_bayer_demosaic.sv
// ----------------------------------------------------------------------------
// tb_bilinear_bayer_demosaic
// Self-checking bench for the streaming RGGB bilinear demosaic: a short
// directed frame table, then random frames over several frame shapes, all
// scored against a cycle-free predictor of the window and line stores.
// ----------------------------------------------------------------------------
module tb_bilinear_bayer_demosaic;
  import bbd_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;

  // one demosaiced pixel as it leaves the block
  typedef struct packed {
    logic [11:0] x;
    logic [15:0] y;
    pix_t        px;
    logic        last;
  } dm_out_t;

  // one row of the directed table, with an optional typed-in last result
  typedef struct packed {
    logic    fs;
    pix_t    px;
    logic    typed;
    dm_out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  bbd_cfg_if cfg_ch ();
  bbd_pix_if pix_ch ();
  bbd_res_if res_ch ();

  bilinear_bayer_demosaic i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .pixels  (pix_ch),
    .results (res_ch)
  );

  // 2 time unit period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: register copies, line stores, window, raster position
  // ---------------------------------------------------------------------------
  logic [12:0] fw_reg = FRAME_WIDTH_RST;
  logic [15:0] fh_reg = FRAME_HEIGHT_RST;
  pix_t        older_row [MAX_W];
  pix_t        newer_row [MAX_W];
  pix_t        win_col [6];       // two previous window columns: top, mid, bot
  int          col_pos = 0;
  int          row_pos = 0;

  dm_out_t     expected_pixels [$];

  // bench bookkeeping
  int          errors = 0;
  int          pixels_sent = 0;
  int          results_seen = 0;
  int          cfg_writes = 0;
  bit          calm = 1'b0;       // no idling on either side while set
  int          hold_requests = 0; // bumped by stimulus, served by the receiver
  int          hold_grants = 0;
  int          hold_left = 0;
  stim_row_t   dir_tab [24];
  dm_out_t     mon_want;

  initial begin
    for (int k = 0; k < MAX_W; k++) begin
      older_row[k] = '0;
      newer_row[k] = '0;
    end
    for (int k = 0; k < 6; k++) win_col[k] = '0;
  end

  task automatic queue_pixel(input int x, input int y, input pix_t p);
    dm_out_t o;
    o.x    = x[11:0];
    o.y    = y[15:0];
    o.px   = p;
    o.last = 1'b0;
    expected_pixels.push_back(o);
  endtask

  // one raster pixel into the demosaic predictor; queues what it releases
  task automatic demosaic_step(input bit fs, input pix_t cur);
    int   w, h, x, y, idx, cx, cy, n0, k;
    pix_t top, mid, p;
    pix_t nb [3][3];
    bit   lastcol, lastrow;
    w = (fw_reg < 3) ? 3 : ((fw_reg > MAX_W) ? MAX_W : int'(fw_reg));
    h = (fh_reg < 3) ? 3 : int'(fh_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    x       = col_pos;
    y       = row_pos;
    idx     = (x < MAX_W) ? x : MAX_W - 1;
    top     = older_row[idx];
    mid     = newer_row[idx];
    lastcol = (x >= w - 1);
    lastrow = (y >= h - 1);
    n0      = expected_pixels.size();

    // pixel up and left of the incoming one
    if (y >= 1 && x >= 1) begin
      cx = x - 1;
      cy = y - 1;
      if (cx >= 1 && cx <= w - 2 && cy >= 1 && cy <= h - 2) begin
        for (k = 0; k < 3; k++) begin
          nb[k][0] = win_col[k];
          nb[k][1] = win_col[3 + k];
        end
        nb[0][2] = top;
        nb[1][2] = mid;
        nb[2][2] = cur;
        p = nb[1][1];
        if (!cx[0] && !cy[0]) begin
          // red site: cross greens, diagonal blues
          p.g = (nb[0][1].g >> 2) + (nb[2][1].g >> 2) + (nb[1][0].g >> 2) + (nb[1][2].g >> 2);
          p.b = (nb[0][0].b >> 2) + (nb[0][2].b >> 2) + (nb[2][0].b >> 2) + (nb[2][2].b >> 2);
        end else if (cx[0] && cy[0]) begin
          // blue site: diagonal reds, cross greens
          p.r = (nb[0][0].r >> 2) + (nb[0][2].r >> 2) + (nb[2][0].r >> 2) + (nb[2][2].r >> 2);
          p.g = (nb[0][1].g >> 2) + (nb[2][1].g >> 2) + (nb[1][0].g >> 2) + (nb[1][2].g >> 2);
        end else if (!cx[0]) begin
          // green on a blue row: red above and below, blue left and right
          p.r = (nb[0][1].r >> 1) + (nb[2][1].r >> 1);
          p.b = (nb[1][0].b >> 1) + (nb[1][2].b >> 1);
        end else begin
          // green on a red row: red left and right, blue above and below
          p.r = (nb[1][0].r >> 1) + (nb[1][2].r >> 1);
          p.b = (nb[0][1].b >> 1) + (nb[2][1].b >> 1);
        end
      end else begin
        p = win_col[4];
      end
      queue_pixel(cx, cy, p);
    end
    if (y >= 1 && lastcol) queue_pixel(x, y - 1, mid);
    if (lastrow) queue_pixel(x, y, cur);
    if (expected_pixels.size() > n0)
      expected_pixels[expected_pixels.size() - 1].last = 1'b1;

    older_row[idx] = mid;
    newer_row[idx] = cur;
    win_col[0] = win_col[3];
    win_col[1] = win_col[4];
    win_col[2] = win_col[5];
    win_col[3] = top;
    win_col[4] = mid;
    win_col[5] = cur;
    if (lastcol) begin
      col_pos = 0;
      row_pos = lastrow ? 0 : ((row_pos + 1) & 16'hFFFF);
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers, all inputs change on the falling edge
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (which == REG_FRAME_WIDTH) fw_reg = val[12:0];
    else fh_reg = val;
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_pixel(input bit fs, input pix_t px);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 7) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.chan_r      <= px.r;
    pix_ch.chan_g      <= px.g;
    pix_ch.chan_b      <= px.b;
    pix_ch.frame_start <= fs;
    do @(posedge clk); while (!pix_ch.ready);
    demosaic_step(fs, px);
    pixels_sent++;
  endtask

  // drop valid and let every queued pixel drain; the extra cycles cover a
  // transaction that is still inside the pipe without producing anything
  task automatic wait_idle();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic stim_row_t mk_row(input bit fs, input logic [7:0] r, g, b,
                                       input bit typed, input int ex, ey,
                                       input logic [7:0] er, eg, eb);
    stim_row_t s;
    s.fs        = fs;
    s.px.r      = r;
    s.px.g      = g;
    s.px.b      = b;
    s.typed     = typed;
    s.want.x    = ex[11:0];
    s.want.y    = ey[15:0];
    s.want.px.r = er;
    s.want.px.g = eg;
    s.want.px.b = eb;
    s.want.last = 1'b1;
    return s;
  endfunction

  // one stretch of random frames under one frame shape
  task automatic run_phase(input logic [CFG_DW-1:0] wdat, hdat, input int n,
                           input bit quiet, input bit squeeze);
    pix_t px;
    bit   fs;
    int   i;
    wait_idle();
    write_reg(REG_FRAME_WIDTH, wdat);
    write_reg(REG_FRAME_HEIGHT, hdat);
    calm = quiet;
    for (i = 0; i < n; i++) begin
      // long output hold while pixels keep coming, then a full drain
      if (squeeze && i == 6) hold_requests++;
      if (squeeze && i == n / 2) wait_idle();
      // every phase opens a fresh frame; a few restarts land mid-frame
      fs   = (i == 0) || ($urandom_range(99) < 3);
      px.r = rand_chan();
      px.g = rand_chan();
      px.b = rand_chan();
      send_pixel(fs, px);
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready pattern and scoreboard
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_grants != hold_requests) begin
      hold_grants = hold_requests;
      hold_left   = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  task automatic check_field(input string tag, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch at (%0d,%0d): expected %0d, got %0d", $time, tag,
               mon_want.x, mon_want.y, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result (%0d,%0d) rgb %0d %0d %0d", $time, res_ch.out_x,
                 res_ch.out_y, res_ch.out_r, res_ch.out_g, res_ch.out_b);
        errors++;
      end else begin
        mon_want = expected_pixels.pop_front();
        check_field("out_x", mon_want.x, res_ch.out_x);
        check_field("out_y", mon_want.y, res_ch.out_y);
        check_field("out_r", mon_want.px.r, res_ch.out_r);
        check_field("out_g", mon_want.px.g, res_ch.out_g);
        check_field("out_b", mon_want.px.b, res_ch.out_b);
        check_field("last_of_run", mon_want.last, res_ch.last_of_run);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : main
    int i;
    pix_ch.valid       = 1'b0;
    pix_ch.chan_r      = '0;
    pix_ch.chan_g      = '0;
    pix_ch.chan_b      = '0;
    pix_ch.frame_start = 1'b0;
    res_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_FRAME_WIDTH;
    cfg_ch.data        = '0;
    rst                = 1'b1;

    // directed table, 3x3 frames; typed values are the last result of a
    // transaction, which is always a plain pass-through here
    // frame one: saturated corners so the blue-site center truncates to 252
    dir_tab[0]  = mk_row(1, 255, 0, 255,   0, 0, 0, 0, 0, 0);
    dir_tab[1]  = mk_row(0, 17, 255, 34,   0, 0, 0, 0, 0, 0);
    dir_tab[2]  = mk_row(0, 255, 128, 1,   0, 0, 0, 0, 0, 0);
    dir_tab[3]  = mk_row(0, 3, 255, 7,     0, 0, 0, 0, 0, 0);
    dir_tab[4]  = mk_row(0, 0, 0, 255,     1, 0, 0, 255, 0, 255);
    dir_tab[5]  = mk_row(0, 9, 254, 11,    1, 2, 0, 255, 128, 1);
    dir_tab[6]  = mk_row(0, 255, 64, 255,  1, 0, 2, 255, 64, 255);
    dir_tab[7]  = mk_row(0, 21, 255, 43,   1, 1, 2, 21, 255, 43);
    dir_tab[8]  = mk_row(0, 255, 99, 255,  1, 2, 2, 255, 99, 255);
    // frame two follows without a frame start: the row counter wraps
    dir_tab[9]  = mk_row(0, 0, 0, 0,       0, 0, 0, 0, 0, 0);
    dir_tab[10] = mk_row(0, 255, 255, 255, 0, 0, 0, 0, 0, 0);
    dir_tab[11] = mk_row(0, 0, 0, 0,       0, 0, 0, 0, 0, 0);
    dir_tab[12] = mk_row(0, 255, 255, 255, 0, 0, 0, 0, 0, 0);
    dir_tab[13] = mk_row(0, 1, 1, 1,       1, 0, 0, 0, 0, 0);
    dir_tab[14] = mk_row(0, 255, 255, 255, 1, 2, 0, 0, 0, 0);
    dir_tab[15] = mk_row(0, 0, 0, 0,       1, 0, 2, 0, 0, 0);
    dir_tab[16] = mk_row(0, 255, 255, 255, 1, 1, 2, 255, 255, 255);
    dir_tab[17] = mk_row(0, 0, 0, 0,       1, 2, 2, 0, 0, 0);
    // frame start in the middle of row one drops what was pending
    dir_tab[18] = mk_row(1, 200, 100, 50,  0, 0, 0, 0, 0, 0);
    dir_tab[19] = mk_row(0, 1, 2, 3,       0, 0, 0, 0, 0, 0);
    dir_tab[20] = mk_row(0, 4, 5, 6,       0, 0, 0, 0, 0, 0);
    dir_tab[21] = mk_row(0, 7, 8, 9,       0, 0, 0, 0, 0, 0);
    dir_tab[22] = mk_row(1, 128, 128, 128, 0, 0, 0, 0, 0, 0);
    dir_tab[23] = mk_row(0, 127, 127, 127, 0, 0, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // width and height below the floor both act as 3
    write_reg(REG_FRAME_WIDTH, 16'd0);
    write_reg(REG_FRAME_HEIGHT, 16'd1);
    for (i = 0; i < 24; i++) begin
      send_pixel(dir_tab[i].fs, dir_tab[i].px);
      if (dir_tab[i].typed &&
          expected_pixels[expected_pixels.size() - 1] != dir_tab[i].want) begin
        $display("%0t: table row %0d: expected %h, predicted %h", $time, i,
                 dir_tab[i].want, expected_pixels[expected_pixels.size() - 1]);
        errors++;
        expected_pixels[expected_pixels.size() - 1] = dir_tab[i].want;
      end
    end

    // random frames: width, height, transactions, no idling, output hold
    run_phase(16'd4, 16'd4, 34, 1'b0, 1'b1);
    run_phase(16'd5, 16'd2, 15, 1'b0, 1'b0);
    run_phase(16'd8, 16'd5, 40, 1'b1, 1'b0);
    run_phase(16'd6, 16'hFFFF, 12, 1'b0, 1'b0);  // tallest frame, last row never reached
    run_phase(16'd1, 16'd0, 12, 1'b0, 1'b0);
    run_phase(16'd7, 16'd4, 14, 1'b0, 1'b0);
    // upper bits of the width write fall outside the register: acts as 4
    run_phase(16'hE004, 16'd3, 12, 1'b0, 1'b0);
    run_phase(16'd3, 16'd3, 12, 1'b0, 1'b0);

    wait_idle();
    repeat (20) @(posedge clk);

    $display("run covered %0d pixel transactions, %0d results and %0d register writes",
             pixels_sent, results_seen, cfg_writes);
    $display("frame shapes from 3x3 up to 8 wide, restarts mid-frame and an output hold");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
